>>> src/steering_angle_select_smooth_macros.svh
// Assertion macros for the steering angle select and smooth block.
// Depends on nothing; included by the top level, which provides clk and rst.
`ifndef STEERING_ANGLE_SELECT_SMOOTH_MACROS_SVH
`define STEERING_ANGLE_SELECT_SMOOTH_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define SASS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define SASS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SASS_ASSERT_SAME(label, ante, cons)
`define SASS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/sass_pkg.sv
// Shared types, widths and codes for the steering angle select and smooth block.
// Depends on nothing; the interfaces, memory, divider and top level import it.
`timescale 1ns / 1ps

package sass_pkg;

  localparam int HISTORY_DEPTH = 16;
  localparam int ANGLE_W = 16;
  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W = ANGLE_W + $clog2(HISTORY_DEPTH);
  localparam int DIVD_W = ANGLE_W + $clog2(HISTORY_DEPTH + 1);
  localparam int DVSR_W = $clog2(HISTORY_DEPTH + 2);
  localparam int WIN_W = 5;
  localparam int CMP_W = (WIN_W > DVSR_W) ? WIN_W : DVSR_W;
  localparam int MISS_W = 8;
  localparam int SPEED_W = 2;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [MISS_W-1:0] MISS_LIMIT = MISS_W'(5);
  localparam logic [MISS_W-1:0] MISS_MAX = '1;

  localparam logic [SPEED_W-1:0] SPEED_DEFAULT = 2'd0;
  localparam logic [SPEED_W-1:0] SPEED_CRUISE = 2'd1;
  localparam logic [SPEED_W-1:0] SPEED_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

  // One access to the history memory: an optional write and an optional read.
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ANGLE_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

>>> src/sass_if.sv
// Valid/ready channel interfaces for the proposal and command streams.
// Depends on sass_pkg for the angle and speed widths.
`timescale 1ns / 1ps

interface sass_in_if;
  import sass_pkg::*;
  logic               valid;
  logic               ready;
  logic               left_found;
  logic [ANGLE_W-1:0] left_angle;
  logic               right_found;
  logic [ANGLE_W-1:0] right_angle;

  modport source (output valid, left_found, left_angle, right_found, right_angle,
                  input ready);
  modport sink (input valid, left_found, left_angle, right_found, right_angle,
                output ready);
endinterface

interface sass_out_if;
  import sass_pkg::*;
  logic               valid;
  logic               ready;
  logic               angle_valid;
  logic [ANGLE_W-1:0] steer_angle;
  logic [SPEED_W-1:0] speed_mode;

  modport source (output valid, angle_valid, steer_angle, speed_mode, input ready);
  modport sink (input valid, angle_valid, steer_angle, speed_mode, output ready);
endinterface

>>> src/sass_hist_ram.sv
// Angle history memory: one write and one registered read per cycle.
// Depends on sass_pkg for the depth, widths and request struct.
`timescale 1ns / 1ps

module sass_hist_ram (
  input  logic                        clk,
  input  sass_pkg::ram_req_t          req,
  output logic [sass_pkg::ANGLE_W-1:0] rd_data
);
  import sass_pkg::*;

  logic [ANGLE_W-1:0] mem [HISTORY_DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

>>> src/sass_div.sv
// Restoring divider, one quotient bit per cycle, for the history mean.
// Depends on sass_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module sass_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [sass_pkg::DIVD_W-1:0] dividend,
  input  logic [sass_pkg::DVSR_W-1:0] divisor,
  output logic                        done,
  output logic [sass_pkg::DIVD_W-1:0] quotient
);
  import sass_pkg::*;

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic [DIVD_W-1:0] quo;
  logic [DVSR_W:0]   trial;
  logic [DVSR_W:0]   diff;
  logic              fits;

  // Shift the next dividend bit into the remainder and try the subtraction.
  always_comb begin
    trial = {rem, quo[DIVD_W-1]};
    diff = trial - {1'b0, dvsr};
    fits = trial >= {1'b0, dvsr};
  end

  // Control: run DIVD_W steps after start, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        steps <= STEP_W'(DIVD_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits from the right.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
      quo <= {quo[DIVD_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

>>> src/steering_angle_select_smooth.sv
// Top level: target selection, miss counting, history update and output register.
// Depends on sass_pkg, sass_if, sass_hist_ram, sass_div and the assertion macros.
//
// Usage: each beat on the proposal channel carries one frame's left and right
// line proposals; each produces exactly one beat on the command channel with
// angle_valid, steer_angle and speed_mode. Both channels are valid/ready.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle: index 0 is left_line_enable, index 1 is smoothing_window.
// Sequencing: with no target or with smoothing off, the accepted proposal goes
// straight to the done state, which loads the output register. With smoothing on,
// an update state writes the history and starts the serial divider, which takes
// one dividend bit per step; its quotient is captured, then the output loaded.
// Flow: one proposal at a time; the next is taken the cycle after the
// previous command is loaded into the output register, even while that command
// still waits. If the receiver stalls, the finished command holds in its
// register and the next item waits there too.
// Reset: left_line_enable 1, smoothing_window 0, history empty, miss count 0.
// The history memory itself is not cleared; only written entries are read.
`timescale 1ns / 1ps
`include "steering_angle_select_smooth_macros.svh"

module steering_angle_select_smooth (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sass_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sass_pkg::CFG_W-1:0]     cfg_data,
  sass_in_if.sink                        proposal,
  sass_out_if.source                     command
);
  import sass_pkg::*;

  state_t state;
  state_t state_next;

  logic               left_line_enable;
  logic [WIN_W-1:0]   smoothing_window;
  logic [ANGLE_W-1:0] tgt;
  logic [IDX_W-1:0]   oldest_slot;
  logic [CNT_W-1:0]   history_count;
  logic [SUM_W-1:0]   history_sum;
  logic [MISS_W-1:0]  miss_count;
  logic               res_valid;
  logic [ANGLE_W-1:0] res_angle;
  logic [SPEED_W-1:0] res_speed;

  logic               in_acc;
  logic               out_load;
  logic               have_tgt;
  logic [ANGLE_W-1:0] tgt_c;
  logic [ANGLE_W:0]   pair_sum;
  logic [IDX_W:0]     tail_pos;
  logic [IDX_W-1:0]   tail_slot;
  logic [IDX_W-1:0]   oldest_inc;
  logic [DVSR_W-1:0]  cnt_inc;
  logic               hist_full;
  logic               hist_drop;
  logic [DIVD_W-1:0]  sum_add;
  logic [DIVD_W-1:0]  sum_swap;
  logic [ANGLE_W-1:0] rd_data;
  ram_req_t           ram_req;
  logic               div_start;
  logic               div_done;
  logic [DIVD_W-1:0]  quotient;

  sass_hist_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  sass_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_add),
    .divisor  (cnt_inc),
    .done     (div_done),
    .quotient (quotient)
  );

  assign in_acc = proposal.valid && proposal.ready;
  assign out_load = (state == ST_DONE) && (!command.valid || command.ready);

  // Target choice from this frame's proposals.
  always_comb begin
    pair_sum = {1'b0, proposal.left_angle} + {1'b0, proposal.right_angle};
    have_tgt = 1'b1;
    tgt_c = '0;
    if (proposal.left_found && proposal.right_found && left_line_enable) begin
      tgt_c = pair_sum[ANGLE_W:1];
    end else if (proposal.left_found && left_line_enable) begin
      tgt_c = proposal.left_angle;
    end else if (proposal.right_found) begin
      tgt_c = proposal.right_angle;
    end else begin
      have_tgt = 1'b0;
    end
  end

  // History ring arithmetic for the update cycle.
  always_comb begin
    tail_pos = (IDX_W + 1)'(oldest_slot) + (IDX_W + 1)'(history_count);
    tail_slot = (tail_pos >= (IDX_W + 1)'(HISTORY_DEPTH)) ?
                IDX_W'(tail_pos - (IDX_W + 1)'(HISTORY_DEPTH)) : tail_pos[IDX_W-1:0];
    oldest_inc = (oldest_slot == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_slot + 1'b1;
    cnt_inc = DVSR_W'(history_count) + 1'b1;
    hist_full = history_count == CNT_W'(HISTORY_DEPTH);
    hist_drop = CMP_W'(cnt_inc) > CMP_W'(smoothing_window);
    sum_add = DIVD_W'(history_sum) + DIVD_W'(tgt);
    sum_swap = sum_add - DIVD_W'(rd_data);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (have_tgt && (smoothing_window != '0)) begin
            state_next = ST_UPDATE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_UPDATE: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs: ready, memory requests and divider start.
  always_comb begin
    proposal.ready = 1'b0;
    div_start = 1'b0;
    ram_req = '0;
    ram_req.raddr = oldest_slot;
    ram_req.wdata = tgt;
    ram_req.waddr = hist_full ? oldest_slot : tail_slot;
    case (state)
      ST_IDLE: begin
        proposal.ready = 1'b1;
        ram_req.re = 1'b1;
      end
      ST_UPDATE: begin
        ram_req.we = 1'b1;
        div_start = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_line_enable <= 1'b1;
      smoothing_window <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT_EN: left_line_enable <= cfg_data[0];
        CFG_WINDOW: smoothing_window <= cfg_data[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state, miss counter and history bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      miss_count <= '0;
      oldest_slot <= '0;
      history_count <= '0;
      history_sum <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (have_tgt) begin
          miss_count <= '0;
        end else if (miss_count != MISS_MAX) begin
          miss_count <= miss_count + 1'b1;
        end
      end
      if (state == ST_UPDATE) begin
        if (hist_full) begin
          history_sum <= SUM_W'(sum_swap);
          oldest_slot <= oldest_inc;
        end else if (hist_drop) begin
          history_sum <= SUM_W'(sum_swap);
          oldest_slot <= oldest_inc;
        end else begin
          history_sum <= SUM_W'(sum_add);
          history_count <= CNT_W'(cnt_inc);
        end
      end
    end
  end

  // Result payload of the item at work.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt <= tgt_c;
      res_valid <= have_tgt;
      if (have_tgt) begin
        res_angle <= tgt_c;
        res_speed <= SPEED_CRUISE;
      end else begin
        res_angle <= '0;
        res_speed <= (miss_count > MISS_LIMIT) ? SPEED_STOP : SPEED_DEFAULT;
      end
    end else if (div_done) begin
      res_angle <= quotient[ANGLE_W-1:0];
    end
  end

  // Output register toward the command channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      command.valid <= 1'b0;
    end else if (out_load) begin
      command.valid <= 1'b1;
    end else if (command.ready) begin
      command.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      command.angle_valid <= res_valid;
      command.steer_angle <= res_angle;
      command.speed_mode <= res_speed;
    end
  end

  // Checks on the sequencer and the command payload.
  `SASS_ASSERT_NEXT(a_update_to_divide, state == ST_UPDATE, state == ST_DIVIDE)
  `SASS_ASSERT_SAME(a_done_in_divide, div_done, state == ST_DIVIDE)
  `SASS_ASSERT_NEXT(a_direct_path, in_acc && (smoothing_window == '0), state == ST_DONE)
  `SASS_ASSERT_SAME(a_stop_no_angle, command.valid && (command.speed_mode == SPEED_STOP),
                    !command.angle_valid)

endmodule
